@@ rtl/spp_pkg.sv @@
package spp_pkg;

  // Default build values
  localparam int PHASE_BITS_DEF     = 12;
  localparam int COEF_FRAC_BITS_DEF = 14;

  // Sine pipeline depth in stages
  localparam int SIN_LAT = 5;

  // Odd polynomial for the first-quadrant sine, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42272;
  localparam logic [12:0] SIN_C = 13'd4864;

  // Configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int COEF_W     = 16;
  localparam int OFFSET_W   = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIN_THETA   = 3'd0,
    REG_COS_THETA   = 3'd1,
    REG_SIN_PHI     = 3'd2,
    REG_COS_PHI     = 3'd3,
    REG_VIEW_OFFSET = 3'd4
  } cfg_reg_e;

  // Reset values of the view registers
  localparam logic signed [COEF_W-1:0]   SIN_THETA_RST   = -16'sd15901;
  localparam logic signed [COEF_W-1:0]   COS_THETA_RST   = 16'sd3949;
  localparam logic signed [COEF_W-1:0]   SIN_PHI_RST     = -16'sd4299;
  localparam logic signed [COEF_W-1:0]   COS_PHI_RST     = 16'sd15811;
  localparam logic signed [OFFSET_W-1:0] VIEW_OFFSET_RST = 9'sd10;

  // Output field widths
  localparam int SCREEN_W = 10;
  localparam int DEPTH_W  = 11;

endpackage

@@ rtl/spp_sine.sv @@
module spp_sine import spp_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic [SIN_LAT-1:0]               en_i,
  input  logic [PHASE_BITS-1:0]            phase_i,
  output logic signed [COEF_FRAC_BITS+1:0] sine_o
);

  localparam int RW      = PHASE_BITS - 2;
  localparam int QUARTER = 1 << RW;
  localparam int SH      = 16 - COEF_FRAC_BITS;
  localparam int RND     = (1 << SH) >> 1;
  localparam int SNW     = COEF_FRAC_BITS + 2;

  // Stage 1: fold to first quadrant, scale to Q16
  logic [1:0]    quad;
  logic [RW:0]   fold;
  logic [16:0]   z_d;
  logic [16:0]   z_q   [1:4];
  logic          neg_q [1:4];

  always_comb begin
    quad = phase_i[PHASE_BITS-1 -: 2];
    fold = {1'b0, phase_i[RW-1:0]};
    if (quad[0]) begin
      fold = (RW+1)'(QUARTER) - {1'b0, phase_i[RW-1:0]};
    end
    z_d = 17'(fold) << (18 - PHASE_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      z_q[1]   <= z_d;
      neg_q[1] <= quad[1];
    end
    for (int k = 2; k <= 4; k++) begin
      if (en_i[k-1]) begin
        z_q[k]   <= z_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // Stage 2: z squared
  logic [33:0] zz_prod;
  logic [16:0] zz2_q, zz3_q;
  assign zz_prod = z_q[1] * z_q[1];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) zz2_q <= zz_prod[32:16];
    if (en_i[2]) zz3_q <= zz2_q;
  end

  // Stage 3: inner term B - z^2 C
  logic [29:0] c_prod;
  logic [15:0] t_q;
  assign c_prod = zz2_q * SIN_C;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) t_q <= SIN_B - 16'(c_prod[29:16]);
  end

  // Stage 4: A - z^2 t
  logic [32:0] t_prod;
  logic [16:0] t2_q;
  assign t_prod = zz3_q * t_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) t2_q <= SIN_A - t_prod[32:16];
  end

  // Stage 5: final product, cap, round to coefficient precision, sign
  logic [33:0]                  s_prod;
  logic [17:0]                  s_raw;
  logic [16:0]                  s_cap;
  logic [17:0]                  s_rnd;
  logic [COEF_FRAC_BITS:0]      s_mag;
  logic signed [SNW-1:0]        s_pos;
  logic signed [SNW-1:0]        sine_q;

  always_comb begin
    s_prod = z_q[4] * t2_q;
    s_raw  = s_prod[33:16];
    s_cap  = (s_raw > 18'd65536) ? 17'h10000 : s_raw[16:0];
    s_rnd  = 18'(s_cap) + 18'(RND);
    s_mag  = (COEF_FRAC_BITS+1)'(s_rnd >> SH);
    s_pos  = $signed({1'b0, s_mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) sine_q <= neg_q[4] ? -s_pos : s_pos;
  end

  assign sine_o = sine_q;

endmodule

@@ rtl/sphere_point_parallel_projection_unit.sv @@
// Sphere point parallel projection: each request (radius, longitude phase,
// latitude phase) becomes one surface point of the sphere, turned by the view
// angles held in the configuration registers and flattened to screen x, y and
// a depth with the view offset added, all rounded half up and saturated. The
// datapath is an 11-stage pipeline: four sines in 5 stages of polynomial
// evaluation, two stages forming the point, one rounding stage, one stage of
// view-matrix products, one stage of partial sums and the output register.
// One request is taken every clock while in_stall_o is low; if the output
// stalls, empty stages keep filling, so input stall rises only once every
// stage holds a request. View registers take effect only for requests taken
// after the write if written while the pipeline is empty, which the block
// does not check; view-matrix coefficient products are registered from them.
module sphere_point_parallel_projection_unit import spp_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [COEF_W-1:0]            cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   radius_i,
  input  logic [PHASE_BITS-1:0]        long_phase_i,
  input  logic signed [PHASE_BITS-1:0] lat_phase_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SCREEN_W-1:0]   screen_x_o,
  output logic signed [SCREEN_W-1:0]   screen_y_o,
  output logic signed [DEPTH_W-1:0]    depth_o
);

  localparam int F       = COEF_FRAC_BITS;
  localparam int NST     = SIN_LAT + 6;
  localparam int S_MUL1  = SIN_LAT + 1;
  localparam int S_MUL2  = SIN_LAT + 2;
  localparam int S_RND   = SIN_LAT + 3;
  localparam int S_PROD  = SIN_LAT + 4;
  localparam int S_SUM   = SIN_LAT + 5;
  localparam int QUARTER = 1 << (PHASE_BITS - 2);

  localparam int SNW = F + 2;      // sine
  localparam int PW  = F + 11;     // point coordinate and r*sine
  localparam int PFW = 2 * F + 13; // r*cos*cos before rounding
  localparam int CPW = 2 * COEF_W; // product of two view coefficients
  localparam int XW  = F + 29;     // screen x sum
  localparam int SW  = F + 45;     // screen y and depth sums
  localparam int XTW = XW - F;
  localparam int YTW = SW - 2 * F;
  localparam int DTW = SW - 3 * F;

  localparam logic signed [PFW-1:0] PX_RND  = PFW'(1) <<< (F - 1);
  localparam logic signed [XW-1:0]  X_RND   = XW'(1) <<< (F - 1);
  localparam logic signed [SW-1:0]  Y_RND   = SW'(1) <<< (2 * F - 1);
  localparam logic signed [SW-1:0]  D_RND   = SW'(1) <<< (3 * F - 1);
  localparam logic signed [SNW-1:0] SIN_MAX = SNW'(1) <<< F;

  localparam logic signed [XTW-1:0] X_MIN = XTW'(-512);
  localparam logic signed [XTW-1:0] X_MAX = XTW'(511);
  localparam logic signed [YTW-1:0] Y_MIN = YTW'(-512);
  localparam logic signed [YTW-1:0] Y_MAX = YTW'(511);
  localparam logic signed [DTW-1:0] D_MIN = DTW'(-1024);
  localparam logic signed [DTW-1:0] D_MAX = DTW'(1023);

  // ---------------------------------------------------------------------------
  // View registers
  logic signed [COEF_W-1:0]   sin_theta_q, cos_theta_q, sin_phi_q, cos_phi_q;
  logic signed [OFFSET_W-1:0] view_offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_theta_q   <= SIN_THETA_RST;
      cos_theta_q   <= COS_THETA_RST;
      sin_phi_q     <= SIN_PHI_RST;
      cos_phi_q     <= COS_PHI_RST;
      view_offset_q <= VIEW_OFFSET_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SIN_THETA:   sin_theta_q   <= cfg_data_i;
        REG_COS_THETA:   cos_theta_q   <= cfg_data_i;
        REG_SIN_PHI:     sin_phi_q     <= cfg_data_i;
        REG_COS_PHI:     cos_phi_q     <= cfg_data_i;
        REG_VIEW_OFFSET: view_offset_q <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient pairs of the view matrix
  logic signed [CPW-1:0] ctsp_q, stsp_q, ctcp_q, stcp_q;

  always_ff @(posedge clk_i) begin
    ctsp_q <= cos_theta_q * sin_phi_q;
    stsp_q <= sin_theta_q * sin_phi_q;
    ctcp_q <= cos_theta_q * cos_phi_q;
    stcp_q <= sin_theta_q * cos_phi_q;
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow: a stage loads when it is empty or its successor loads
  logic [NST:1]   valid_q;
  logic [NST+1:1] en;

  always_comb begin
    en[NST+1] = !out_stall_i;
    for (int k = NST; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) valid_q[1] <= in_valid_i;
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1 to 5: the four sines, radius carried alongside
  logic [7:0]            r_q [1:SIN_LAT];
  logic signed [SNW-1:0] cu, su, cv, sv;
  logic [PHASE_BITS-1:0] long_cos_ph, lat_ph, lat_cos_ph;

  assign long_cos_ph = long_phase_i + PHASE_BITS'(QUARTER);
  assign lat_ph      = lat_phase_i;
  assign lat_cos_ph  = lat_ph + PHASE_BITS'(QUARTER);

  always_ff @(posedge clk_i) begin
    if (en[1]) r_q[1] <= radius_i;
    for (int k = 2; k <= SIN_LAT; k++) begin
      if (en[k]) r_q[k] <= r_q[k-1];
    end
  end

  spp_sine #(.PHASE_BITS(PHASE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cos_long (
    .clk_i(clk_i), .en_i(en[SIN_LAT:1]), .phase_i(long_cos_ph), .sine_o(cu)
  );
  spp_sine #(.PHASE_BITS(PHASE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sin_long (
    .clk_i(clk_i), .en_i(en[SIN_LAT:1]), .phase_i(long_phase_i), .sine_o(su)
  );
  spp_sine #(.PHASE_BITS(PHASE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cos_lat (
    .clk_i(clk_i), .en_i(en[SIN_LAT:1]), .phase_i(lat_cos_ph), .sine_o(cv)
  );
  spp_sine #(.PHASE_BITS(PHASE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sin_lat (
    .clk_i(clk_i), .en_i(en[SIN_LAT:1]), .phase_i(lat_ph), .sine_o(sv)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: radius times longitude terms and latitude sine
  logic signed [8:0]     r_s;
  logic signed [PW-1:0]  rc_q, rs_q, pz6_q;
  logic signed [SNW-1:0] cv6_q;

  assign r_s = $signed({1'b0, r_q[SIN_LAT]});

  always_ff @(posedge clk_i) begin
    if (en[S_MUL1]) begin
      rc_q  <= r_s * cu;
      rs_q  <= r_s * su;
      pz6_q <= r_s * sv;
      cv6_q <= cv;
    end
  end

  // Stage 7: times latitude cosine
  logic signed [PFW-1:0] pxf_q, pyf_q;
  logic signed [PW-1:0]  pz7_q;

  always_ff @(posedge clk_i) begin
    if (en[S_MUL2]) begin
      pxf_q <= rc_q * cv6_q;
      pyf_q <= rs_q * cv6_q;
      pz7_q <= pz6_q;
    end
  end

  // Stage 8: round x and y of the surface point
  logic signed [PFW-1:0] pxr, pyr;
  logic signed [PW-1:0]  px_q, py_q, pz_q;

  assign pxr = (pxf_q + PX_RND) >>> F;
  assign pyr = (pyf_q + PX_RND) >>> F;

  always_ff @(posedge clk_i) begin
    if (en[S_RND]) begin
      px_q <= pxr[PW-1:0];
      py_q <= pyr[PW-1:0];
      pz_q <= pz7_q;
    end
  end

  // Stage 9: view-matrix products
  logic signed [PW+COEF_W-1:0] x1_q, x2_q, y3_q, d3_q;
  logic signed [PW+CPW-1:0]    y1_q, y2_q, d1_q, d2_q;

  always_ff @(posedge clk_i) begin
    if (en[S_PROD]) begin
      x1_q <= px_q * sin_theta_q;
      x2_q <= py_q * cos_theta_q;
      y1_q <= px_q * ctsp_q;
      y2_q <= py_q * stsp_q;
      y3_q <= pz_q * cos_phi_q;
      d1_q <= px_q * ctcp_q;
      d2_q <= py_q * stcp_q;
      d3_q <= pz_q * sin_phi_q;
    end
  end

  // Stage 10: partial sums, rounding constants folded in
  logic signed [XW-1:0] xs_q;
  logic signed [SW-1:0] ya_q, yb_q, da_q, db_q;

  always_ff @(posedge clk_i) begin
    if (en[S_SUM]) begin
      xs_q <= XW'(x2_q) - XW'(x1_q) + X_RND;
      ya_q <= (SW'(y3_q) <<< F) - SW'(y1_q);
      yb_q <= Y_RND - SW'(y2_q);
      da_q <= -SW'(d1_q) - SW'(d2_q);
      db_q <= (SW'(view_offset_q) <<< (3 * F)) + D_RND - (SW'(d3_q) <<< F);
    end
  end

  // Stage 11: final sums, scale down, saturate
  logic signed [SW-1:0]       ysum, dsum, ysh, dsh;
  logic signed [XW-1:0]       xsh;
  logic signed [XTW-1:0]      xt;
  logic signed [YTW-1:0]      yt;
  logic signed [DTW-1:0]      dt;
  logic signed [SCREEN_W-1:0] sx_d, sy_d, sx_q, sy_q;
  logic signed [DEPTH_W-1:0]  dp_d, dp_q;

  always_comb begin
    ysum = ya_q + yb_q;
    dsum = da_q + db_q;
    xsh  = xs_q >>> F;
    ysh  = ysum >>> (2 * F);
    dsh  = dsum >>> (3 * F);
    xt   = xsh[XTW-1:0];
    yt   = ysh[YTW-1:0];
    dt   = dsh[DTW-1:0];

    if (xt < X_MIN)      sx_d = X_MIN[SCREEN_W-1:0];
    else if (xt > X_MAX) sx_d = X_MAX[SCREEN_W-1:0];
    else                 sx_d = xt[SCREEN_W-1:0];

    if (yt < Y_MIN)      sy_d = Y_MIN[SCREEN_W-1:0];
    else if (yt > Y_MAX) sy_d = Y_MAX[SCREEN_W-1:0];
    else                 sy_d = yt[SCREEN_W-1:0];

    if (dt < D_MIN)      dp_d = D_MIN[DEPTH_W-1:0];
    else if (dt > D_MAX) dp_d = D_MAX[DEPTH_W-1:0];
    else                 dp_d = dt[DEPTH_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[NST]) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      dp_q <= dp_d;
    end
  end

  assign out_valid_o = valid_q[NST];
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign depth_o     = dp_q;

  // ---------------------------------------------------------------------------
  // Checks

  // a taken request always lands in the first stage
  a_take_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[1])
    else $error("accepted request not captured in first stage");

  // input back-pressure only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while pipeline has a bubble");

  // longitude and latitude cosines stay within one unit
  a_sine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[SIN_LAT] |-> (cu <= SIN_MAX && cu >= -SIN_MAX &&
                          cv <= SIN_MAX && cv >= -SIN_MAX))
    else $error("sine out of range");

  // a request behind a stalled output is never dropped
  a_hold_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NST] && out_stall_i && valid_q[NST-1]) |=> valid_q[NST-1])
    else $error("request lost behind stalled output");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import spp_pkg::*;

  localparam int PH_W     = PHASE_BITS_DEF;
  localparam int FRAC     = COEF_FRAC_BITS_DEF;
  localparam int QUARTER  = 1 << (PH_W - 2);
  localparam int PIPE_LAT = 11;
  localparam int HOLD_OFF_CYCLES = 200;

  // first-quadrant sine polynomial, Q16
  localparam longint unsigned POLY_A = 102944;
  localparam longint unsigned POLY_B = 42272;
  localparam longint unsigned POLY_C = 4864;

  localparam longint ONE_Q  = longint'(1) << FRAC;
  localparam longint ONE_Q3 = longint'(1) << (3 * FRAC);

  typedef struct packed {
    logic signed [SCREEN_W-1:0] x;
    logic signed [SCREEN_W-1:0] y;
    logic signed [DEPTH_W-1:0]  depth;
  } screen_point_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [COEF_W-1:0]          cfg_data_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [7:0]                 radius_i;
  logic [PH_W-1:0]            long_phase_i;
  logic signed [PH_W-1:0]     lat_phase_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SCREEN_W-1:0] screen_x_o;
  logic signed [SCREEN_W-1:0] screen_y_o;
  logic signed [DEPTH_W-1:0]  depth_o;

  // predictor copy of the view registers
  logic signed [COEF_W-1:0]   view_st;
  logic signed [COEF_W-1:0]   view_ct;
  logic signed [COEF_W-1:0]   view_sp;
  logic signed [COEF_W-1:0]   view_cp;
  logic signed [OFFSET_W-1:0] view_off;

  screen_point_t expected_points[$];
  int            mismatches;
  bit            tx_gaps;
  bit            rx_gaps;
  bit            hold_off_req;

  sphere_point_parallel_projection_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .radius_i     (radius_i),
    .long_phase_i (long_phase_i),
    .lat_phase_i  (lat_phase_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .screen_x_o   (screen_x_o),
    .screen_y_o   (screen_y_o),
    .depth_o      (depth_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // Q.FRAC sine of a phase, polynomial on the folded quadrant
  function automatic longint sine_q(input logic [PH_W-1:0] ph);
    logic [1:0] quad;
    longint unsigned r, z, z2, t, t2, s;
    quad = ph[PH_W-1 -: 2];
    r    = ph[PH_W-3:0];
    if (quad[0]) r = QUARTER - r;
    z  = r << (18 - PH_W);
    z2 = (z * z) >> 16;
    t  = POLY_B - ((z2 * POLY_C) >> 16);
    t2 = POLY_A - ((z2 * t) >> 16);
    s  = (z * t2) >> 16;
    if (s > 65536) s = 65536;
    s = (s + ((longint'(1) << (16 - FRAC)) >> 1)) >> (16 - FRAC);
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  // half up: floor((v + half) / 2^sh)
  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // surface point of the sphere, turned by the view and flattened
  function automatic screen_point_t project_point(input logic [7:0] rad,
                                                  input logic [PH_W-1:0] lon,
                                                  input logic [PH_W-1:0] lat);
    longint r, cu, su, cv, sv, px, py, pz, xs, ys, ds;
    longint st, ct, sp, cp, off;
    screen_point_t res;
    r   = rad;
    st  = view_st;
    ct  = view_ct;
    sp  = view_sp;
    cp  = view_cp;
    off = view_off;
    cu  = sine_q(lon + QUARTER);
    su  = sine_q(lon);
    cv  = sine_q(lat + QUARTER);
    sv  = sine_q(lat);
    px  = round_half_up(r * cu * cv, FRAC);
    py  = round_half_up(r * su * cv, FRAC);
    pz  = r * sv;
    xs  = -px * st + py * ct;
    ys  = -px * ct * sp - py * st * sp + pz * cp * ONE_Q;
    ds  = -px * ct * cp - py * st * cp - pz * sp * ONE_Q + off * ONE_Q3;
    res.x = SCREEN_W'(clamp(round_half_up(xs, FRAC),
                            -(longint'(1) << (SCREEN_W - 1)),
                            (longint'(1) << (SCREEN_W - 1)) - 1));
    res.y = SCREEN_W'(clamp(round_half_up(ys, 2 * FRAC),
                            -(longint'(1) << (SCREEN_W - 1)),
                            (longint'(1) << (SCREEN_W - 1)) - 1));
    res.depth = DEPTH_W'(clamp(round_half_up(ds, 3 * FRAC),
                               -(longint'(1) << (DEPTH_W - 1)),
                               (longint'(1) << (DEPTH_W - 1)) - 1));
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit enable);
    int roll;
    if (!enable) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one request; returns at the edge it is taken
  task automatic send_point(input logic [7:0] rad, input logic [PH_W-1:0] lon,
                            input logic [PH_W-1:0] lat);
    int gap;
    gap = pick_gap(tx_gaps);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    radius_i     <= rad;
    long_phase_i <= lon;
    lat_phase_i  <= lat;
    do @(posedge clk_i); while (in_stall_o);
    expected_points.push_back(project_point(rad, lon, lat));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_points();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_points.size() != 0);
  endtask

  // write every index, the unused ones with junk; only called while idle
  task automatic load_view(input logic [COEF_W-1:0] st, input logic [COEF_W-1:0] ct,
                           input logic [COEF_W-1:0] sp, input logic [COEF_W-1:0] cp,
                           input logic [OFFSET_W-1:0] off);
    logic [COEF_W-1:0] words [1 << CFG_IDX_W];
    foreach (words[i]) words[i] = $urandom;
    words[REG_SIN_THETA] = st;
    words[REG_COS_THETA] = ct;
    words[REG_SIN_PHI]   = sp;
    words[REG_COS_PHI]   = cp;
    words[REG_VIEW_OFFSET][OFFSET_W-1:0] = off;
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i  <= words[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    view_st  = st;
    view_ct  = ct;
    view_sp  = sp;
    view_cp  = cp;
    view_off = words[REG_VIEW_OFFSET][OFFSET_W-1:0];
  endtask

  // view from two random angles, sometimes raw words outside -1..1
  task automatic load_random_view();
    logic [PH_W-1:0] az, el;
    az = $urandom;
    el = $urandom;
    if ($urandom_range(0, 4) == 0)
      load_view($urandom, $urandom, $urandom, $urandom, $urandom);
    else
      load_view(COEF_W'(sine_q(az)), COEF_W'(sine_q(az + QUARTER)),
                COEF_W'(sine_q(el)), COEF_W'(sine_q(el + QUARTER)), $urandom);
  endtask

  // ---------------------------------------------------------------- receiver

  // random output stalls, or one long hold-off on request
  initial begin
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
        n = pick_gap(1'b1);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic flag_field(input string name, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endtask

  // compare each taken result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    screen_point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, got x %0d y %0d depth %0d",
                 $time, screen_x_o, screen_y_o, depth_o);
      end else begin
        want = expected_points.pop_front();
        if (screen_x_o !== want.x) flag_field("screen_x", want.x, screen_x_o);
        if (screen_y_o !== want.y) flag_field("screen_y", want.y, screen_y_o);
        if (depth_o !== want.depth) flag_field("depth", want.depth, depth_o);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset view; quadrant edges of longitude, poles and wrapped latitude
  task automatic test_reset_view();
    int lon_pts [6] = '{0, 1024, 2048, 3072, 4095, 512};
    int lat_pts [7] = '{-1024, 1024, -512, 512, 2047, -2048, 1};
    foreach (lon_pts[i]) send_point(8'd255, lon_pts[i], 0);
    foreach (lat_pts[i]) send_point(8'd255, 700, lat_pts[i]);
    send_point(8'd0, 1234, 300);
    send_point(8'd128, 4095, 2047);
    send_point(8'd1, 0, -1);
  endtask

  // unit and out-of-range coefficients, offset limits; saturation
  task automatic test_view_extremes();
    logic [COEF_W-1:0]   st_set  [6] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sh7FFF,
                                         16'sh8000, 16'sd16384};
    logic [COEF_W-1:0]   ct_set  [6] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sh8000,
                                         16'sh7FFF, 16'sd0};
    logic [COEF_W-1:0]   sp_set  [6] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sh7FFF,
                                         16'sh8000, 16'sd0};
    logic [COEF_W-1:0]   cp_set  [6] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sh8000,
                                         16'sh7FFF, 16'sd16384};
    logic [OFFSET_W-1:0] off_set [6] = '{9'sd255, 9'sh100, 9'sd0, 9'sd255,
                                         9'sh100, 9'sd1};
    for (int c = 0; c < 6; c++) begin
      drain_points();
      load_view(st_set[c], ct_set[c], sp_set[c], cp_set[c], off_set[c]);
      send_point(8'd255, 0, 0);
      send_point(8'd255, 2048, 1024);
      repeat (6) send_point($urandom, $urandom, $urandom_range(0, 2048) - 1024);
    end
  endtask

  // angle sweeps over the sphere as a feeder would, with noise mixed in
  task automatic test_angle_sweeps();
    logic [7:0] rad;
    int lon, lat, dlon, dlat, roll;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      drain_points();
      load_random_view();
      rad  = $urandom;
      lon  = $urandom_range(0, 4095);
      lat  = $urandom_range(0, 2048) - 1024;
      dlon = $urandom_range(1, 256);
      dlat = $urandom_range(1, 128);
      for (int k = 0; k < 85; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          lon = (lon + dlon) % 4096;
          if (k % 16 == 15) begin
            lat = lat + dlat;
            if (lat > 1024) lat = -1024;
          end
          send_point(rad, lon, lat);
        end else if (roll < 90) begin
          send_point($urandom, $urandom, $urandom_range(0, 2048) - 1024);
        end else begin
          send_point($urandom, $urandom, $urandom);
        end
      end
    end
  endtask

  // back-to-back on both sides
  task automatic test_full_rate();
    drain_points();
    load_random_view();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (100) send_point($urandom, $urandom, $urandom_range(0, 2048) - 1024);
  endtask

  // output held off long enough for the pipeline to fill and stall input
  task automatic test_output_hold_off();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_off_req = 1'b1;
    repeat (60) send_point($urandom, $urandom, $urandom);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (40) send_point($urandom, $urandom, $urandom_range(0, 2048) - 1024);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    radius_i     <= '0;
    long_phase_i <= '0;
    lat_phase_i  <= '0;
    view_st  = SIN_THETA_RST;
    view_ct  = COS_THETA_RST;
    view_sp  = SIN_PHI_RST;
    view_cp  = COS_PHI_RST;
    view_off = VIEW_OFFSET_RST;
    mismatches   = 0;
    tx_gaps      = 1'b1;
    rx_gaps      = 1'b1;
    hold_off_req = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_view();
    test_view_extremes();
    test_angle_sweeps();
    test_full_rate();
    test_output_hold_off();

    drain_points();
    repeat (2 * PIPE_LAT) @(posedge clk_i);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/spp_pkg.sv
rtl/spp_sine.sv
rtl/sphere_point_parallel_projection_unit.sv
tb/sv/tb.sv
